>>> hdl/pulse_tone_channel_defines.svh
// assertion helpers for the checker file
`ifndef PULSE_TONE_CHANNEL_DEFINES_SVH
`define PULSE_TONE_CHANNEL_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define PTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pulse tone channel: same-cycle check failed");

// next-cycle implication, held off while reset is low
`define PTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pulse tone channel: next-cycle check failed");

`endif

>>> hdl/ptc_pkg.sv
package ptc_pkg;

    typedef enum logic [2:0] {
        FUNC_WRITE     = 3'd0,
        FUNC_READ      = 3'd1,
        FUNC_TIMER     = 3'd2,
        FUNC_ENVELOPE  = 3'd3,
        FUNC_LENGTH    = 3'd4,
        FUNC_SWEEP     = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        REG_DUTY_VOL   = 2'd0,
        REG_SWEEP      = 2'd1,
        REG_PERIOD_LO  = 2'd2,
        REG_LENGTH_HI  = 2'd3
    } t_reg_addr;

    typedef struct packed {
        logic [2:0] func;
        logic [1:0] reg_addr;
        logic [7:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] sample;
    } t_out_item;

    localparam logic [10:0] PERIOD_MAX = 11'h7FF;
    localparam logic [3:0]  ENV_TOP    = 4'd15;

    // bit n is the level at duty step n
    localparam logic [7:0] DUTY_WAVE [4] = '{
        8'b1000_0000,
        8'b1100_0000,
        8'b1111_0000,
        8'b0011_1111
    };

    localparam logic [7:0] LENGTH_LOAD [32] = '{
        8'd10,  8'd254, 8'd20,  8'd2,  8'd40,  8'd4,  8'd80,  8'd6,
        8'd160, 8'd8,   8'd60,  8'd10, 8'd14,  8'd12, 8'd26,  8'd14,
        8'd12,  8'd16,  8'd24,  8'd18, 8'd48,  8'd20, 8'd96,  8'd22,
        8'd192, 8'd24,  8'd72,  8'd26, 8'd16,  8'd28, 8'd32,  8'd30
    };

endpackage

>>> hdl/pulse_tone_channel.sv
// Square-wave tone channel with sweep, volume envelope and length counter.
// Every input item (register write, register read, or a timer, envelope,
// length or sweep tick) updates the channel state at the edge it is accepted
// and yields one result item in the next cycle: the read byte (zero unless a
// read) and the 4-bit sample as it stands after the item. One item per clock
// is taken; the only limit is the single result register, which stalls input
// only while its item waits on i_out_ready. The config register is written
// through its own channel, always ready, and must change only while idle.
module pulse_tone_channel (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ptc_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ptc_pkg::t_out_item   o_out_item
);

    logic        r_ones_neg;
    logic [1:0]  r_duty_select,  n_duty_select;
    logic        r_loop_halt,    n_loop_halt;
    logic        r_const_vol,    n_const_vol;
    logic [3:0]  r_volume,       n_volume;
    logic        r_sweep_on,     n_sweep_on;
    logic [2:0]  r_sweep_div,    n_sweep_div;
    logic        r_sweep_down,   n_sweep_down;
    logic [2:0]  r_sweep_amt,    n_sweep_amt;
    logic [10:0] r_tone_period,  n_tone_period;
    logic [4:0]  r_length_index, n_length_index;
    logic        r_env_restart,  n_env_restart;
    logic [3:0]  r_env_level,    n_env_level;
    logic        r_sweep_restart, n_sweep_restart;
    logic [2:0]  r_sweep_count,  n_sweep_count;
    logic [10:0] r_period_count, n_period_count;
    logic [2:0]  r_duty_step,    n_duty_step;
    logic [7:0]  r_length_count, n_length_count;

    logic               r_out_valid;
    ptc_pkg::t_out_item r_out_item;
    ptc_pkg::t_out_item n_out_item;

    logic        in_fire;
    logic [10:0] sweep_delta;
    logic [11:0] sweep_sum;
    logic [11:0] sweep_sub;
    logic [10:0] sweep_target;
    logic [7:0]  rd;
    logic [7:0]  duty_bits;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // sweep target, saturating both ways
    always_comb begin
        sweep_delta = r_tone_period >> r_sweep_amt;
        sweep_sum   = {1'b0, r_tone_period} + {1'b0, sweep_delta};
        sweep_sub   = {1'b0, sweep_delta} + {11'd0, r_ones_neg};
        if (r_sweep_down) begin
            sweep_target = (sweep_sub > {1'b0, r_tone_period}) ? 11'd0
                         : r_tone_period - sweep_sub[10:0];
        end else begin
            sweep_target = sweep_sum[11] ? ptc_pkg::PERIOD_MAX : sweep_sum[10:0];
        end
    end

    always_comb begin
        n_duty_select   = r_duty_select;
        n_loop_halt     = r_loop_halt;
        n_const_vol     = r_const_vol;
        n_volume        = r_volume;
        n_sweep_on      = r_sweep_on;
        n_sweep_div     = r_sweep_div;
        n_sweep_down    = r_sweep_down;
        n_sweep_amt     = r_sweep_amt;
        n_tone_period   = r_tone_period;
        n_length_index  = r_length_index;
        n_env_restart   = r_env_restart;
        n_env_level     = r_env_level;
        n_sweep_restart = r_sweep_restart;
        n_sweep_count   = r_sweep_count;
        n_period_count  = r_period_count;
        n_duty_step     = r_duty_step;
        n_length_count  = r_length_count;
        rd              = 8'd0;

        case (i_in_item.func)
            ptc_pkg::FUNC_WRITE: begin
                case (i_in_item.reg_addr)
                    ptc_pkg::REG_DUTY_VOL: begin
                        n_duty_select = i_in_item.write_data[7:6];
                        n_loop_halt   = i_in_item.write_data[5];
                        n_const_vol   = i_in_item.write_data[4];
                        n_volume      = i_in_item.write_data[3:0];
                    end
                    ptc_pkg::REG_SWEEP: begin
                        n_sweep_on      = i_in_item.write_data[7];
                        n_sweep_div     = i_in_item.write_data[6:4];
                        n_sweep_down    = i_in_item.write_data[3];
                        n_sweep_amt     = i_in_item.write_data[2:0];
                        n_sweep_restart = 1'b1;
                    end
                    ptc_pkg::REG_PERIOD_LO: begin
                        n_tone_period = {r_tone_period[10:8], i_in_item.write_data};
                    end
                    ptc_pkg::REG_LENGTH_HI: begin
                        n_length_index = i_in_item.write_data[7:3];
                        n_tone_period  = {i_in_item.write_data[2:0], r_tone_period[7:0]};
                        n_length_count = ptc_pkg::LENGTH_LOAD[i_in_item.write_data[7:3]];
                        n_env_restart  = 1'b1;
                        n_duty_step    = 3'd0;
                    end
                    default: begin
                    end
                endcase
            end
            ptc_pkg::FUNC_READ: begin
                case (i_in_item.reg_addr)
                    ptc_pkg::REG_DUTY_VOL:
                        rd = {r_duty_select, r_loop_halt, r_const_vol,
                              r_const_vol ? r_volume : r_env_level};
                    ptc_pkg::REG_SWEEP:
                        rd = {r_sweep_on, r_sweep_div, r_sweep_down, r_sweep_amt};
                    ptc_pkg::REG_PERIOD_LO:
                        rd = r_tone_period[7:0];
                    ptc_pkg::REG_LENGTH_HI:
                        rd = {r_length_index, r_tone_period[10:8]};
                    default:
                        rd = 8'd0;
                endcase
            end
            ptc_pkg::FUNC_TIMER: begin
                if (r_period_count != 11'd0) begin
                    n_period_count = r_period_count - 11'd1;
                end else begin
                    n_duty_step    = r_duty_step + 3'd1;
                    n_period_count = r_tone_period;
                end
            end
            ptc_pkg::FUNC_ENVELOPE: begin
                if (r_env_restart) begin
                    n_env_level   = ptc_pkg::ENV_TOP;
                    n_env_restart = 1'b0;
                end else if (r_env_level != 4'd0) begin
                    n_env_level = r_env_level - 4'd1;
                end else if (r_loop_halt) begin
                    n_env_level = ptc_pkg::ENV_TOP;
                end
            end
            ptc_pkg::FUNC_LENGTH: begin
                if (!r_loop_halt && r_length_count != 8'd0) begin
                    n_length_count = r_length_count - 8'd1;
                end
            end
            ptc_pkg::FUNC_SWEEP: begin
                if (r_sweep_restart) begin
                    if (r_sweep_on && r_sweep_count == 3'd0) begin
                        n_tone_period = sweep_target;
                    end
                    n_sweep_count   = r_sweep_div;
                    n_sweep_restart = 1'b0;
                end else if (r_sweep_count != 3'd0) begin
                    n_sweep_count = r_sweep_count - 3'd1;
                end else if (r_sweep_on) begin
                    n_tone_period = sweep_target;
                    n_sweep_count = r_sweep_div;
                end
            end
            default: begin
            end
        endcase

        // sample from the state as it stands after the item
        duty_bits            = ptc_pkg::DUTY_WAVE[n_duty_select];
        n_out_item.read_data = rd;
        if ((!n_loop_halt && n_length_count == 8'd0) || !duty_bits[n_duty_step]) begin
            n_out_item.sample = 4'd0;
        end else begin
            n_out_item.sample = n_const_vol ? n_volume : n_env_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ones_neg      <= 1'b0;
            r_duty_select   <= '0;
            r_loop_halt     <= 1'b0;
            r_const_vol     <= 1'b0;
            r_volume        <= '0;
            r_sweep_on      <= 1'b0;
            r_sweep_div     <= '0;
            r_sweep_down    <= 1'b0;
            r_sweep_amt     <= '0;
            r_tone_period   <= '0;
            r_length_index  <= '0;
            r_env_restart   <= 1'b0;
            r_env_level     <= '0;
            r_sweep_restart <= 1'b0;
            r_sweep_count   <= '0;
            r_period_count  <= '0;
            r_duty_step     <= '0;
            r_length_count  <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_ones_neg <= i_cfg_data;
            end
            if (in_fire) begin
                r_duty_select   <= n_duty_select;
                r_loop_halt     <= n_loop_halt;
                r_const_vol     <= n_const_vol;
                r_volume        <= n_volume;
                r_sweep_on      <= n_sweep_on;
                r_sweep_div     <= n_sweep_div;
                r_sweep_down    <= n_sweep_down;
                r_sweep_amt     <= n_sweep_amt;
                r_tone_period   <= n_tone_period;
                r_length_index  <= n_length_index;
                r_env_restart   <= n_env_restart;
                r_env_level     <= n_env_level;
                r_sweep_restart <= n_sweep_restart;
                r_sweep_count   <= n_sweep_count;
                r_period_count  <= n_period_count;
                r_duty_step     <= n_duty_step;
                r_length_count  <= n_length_count;
                r_out_valid     <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

>>> hdl/ptc_checker.sv
`include "pulse_tone_channel_defines.svh"

module ptc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic               i_cfg_data,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input ptc_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ptc_pkg::t_out_item o_out_item
);

    logic in_fire;
    logic cfg_fire;

    assign in_fire  = i_in_valid && o_in_ready;
    assign cfg_fire = i_cfg_valid && o_cfg_ready && i_cfg_data;

    // a stalled result item holds
    `PTC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item))

    // every accepted item gives a result on the next cycle
    `PTC_ASSERT_NEXT(a_one_result, i_clk, i_rst_n, in_fire, o_out_valid)

    // only a read returns read data
    `PTC_ASSERT_NEXT(a_rd_zero, i_clk, i_rst_n, in_fire && i_in_item.func != ptc_pkg::FUNC_READ, o_out_item.read_data == 8'd0)

    // input stalls only behind a waiting result
    `PTC_ASSERT_NOW(a_ready_cause, i_clk, i_rst_n, !o_in_ready || cfg_fire, o_in_ready || (o_out_valid && !i_out_ready))

endmodule

bind pulse_tone_channel ptc_checker u_ptc_checker (.*);

>>> sim/tb_pulse_tone_channel.sv
`timescale 1ns / 100ps

module tb_pulse_tone_channel;

    localparam int QUIET_LIMIT = 2000;
    localparam int SHOWN_LIMIT = 10;

    // func codes the block leaves unused
    localparam logic [2:0] FUNC_SPARE_A = 3'd6;
    localparam logic [2:0] FUNC_SPARE_B = 3'd7;

    localparam logic [10:0] PERIOD_CEIL = 11'h7FF;
    localparam logic [3:0]  ENV_FULL    = 4'd15;

    // bit n is the level at duty step n
    localparam bit [7:0] WAVE_BITS [4] = '{8'h80, 8'hC0, 8'hF0, 8'h3F};

    localparam bit [7:0] LEN_RELOAD [32] = '{
        8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
        8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
        8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
        8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
    };

    typedef struct packed {
        ptc_pkg::t_in_item  item;
        bit                 fixed;
        ptc_pkg::t_out_item value;
    } t_row;

    localparam int SCRIPT_LEN = 25;

    // fixed rows carry a result that is obvious from reset or all-ones writes
    localparam t_row SCRIPT [SCRIPT_LEN] = '{
        '{'{ptc_pkg::FUNC_READ,     ptc_pkg::REG_DUTY_VOL,  8'h00}, 1'b1, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_READ,     ptc_pkg::REG_SWEEP,     8'hFF}, 1'b1, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_READ,     ptc_pkg::REG_PERIOD_LO, 8'h00}, 1'b1, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_READ,     ptc_pkg::REG_LENGTH_HI, 8'hFF}, 1'b1, '{8'h00, 4'h0}},
        '{'{FUNC_SPARE_A,           ptc_pkg::REG_DUTY_VOL,  8'h00}, 1'b1, '{8'h00, 4'h0}},
        '{'{FUNC_SPARE_B,           ptc_pkg::REG_LENGTH_HI, 8'hFF}, 1'b1, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_WRITE,    ptc_pkg::REG_DUTY_VOL,  8'hFF}, 1'b0, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_READ,     ptc_pkg::REG_DUTY_VOL,  8'h00}, 1'b1, '{8'hFF, 4'hF}},
        '{'{ptc_pkg::FUNC_WRITE,    ptc_pkg::REG_SWEEP,     8'hFF}, 1'b0, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_READ,     ptc_pkg::REG_SWEEP,     8'h00}, 1'b1, '{8'hFF, 4'hF}},
        '{'{ptc_pkg::FUNC_WRITE,    ptc_pkg::REG_PERIOD_LO, 8'hFF}, 1'b0, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_WRITE,    ptc_pkg::REG_LENGTH_HI, 8'hFF}, 1'b0, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_READ,     ptc_pkg::REG_LENGTH_HI, 8'h00}, 1'b1, '{8'hFF, 4'hF}},
        '{'{ptc_pkg::FUNC_TIMER,    ptc_pkg::REG_SWEEP,     8'hA5}, 1'b0, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_ENVELOPE, ptc_pkg::REG_DUTY_VOL,  8'h5A}, 1'b0, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_ENVELOPE, ptc_pkg::REG_LENGTH_HI, 8'h00}, 1'b0, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_LENGTH,   ptc_pkg::REG_PERIOD_LO, 8'hFF}, 1'b0, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_SWEEP,    ptc_pkg::REG_DUTY_VOL,  8'h00}, 1'b0, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_SWEEP,    ptc_pkg::REG_SWEEP,     8'h33}, 1'b0, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_WRITE,    ptc_pkg::REG_DUTY_VOL,  8'h00}, 1'b0, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_WRITE,    ptc_pkg::REG_SWEEP,     8'h80}, 1'b0, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_SWEEP,    ptc_pkg::REG_PERIOD_LO, 8'hCC}, 1'b0, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_READ,     ptc_pkg::REG_PERIOD_LO, 8'h00}, 1'b0, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_WRITE,    ptc_pkg::REG_LENGTH_HI, 8'h08}, 1'b0, '{8'h00, 4'h0}},
        '{'{ptc_pkg::FUNC_LENGTH,   ptc_pkg::REG_SWEEP,     8'h00}, 1'b0, '{8'h00, 4'h0}}
    };

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_data  = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    ptc_pkg::t_in_item  i_in_item   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    ptc_pkg::t_out_item o_out_item;

    // travel with the item so the checker knows which rows are fixed
    bit                 row_fixed = 1'b0;
    ptc_pkg::t_out_item row_value = '0;

    bit        steady = 1'b0;
    int        mismatch_count = 0;
    int        checked_count = 0;
    int        quiet_cycles = 0;
    int        func_seen [8];

    ptc_pkg::t_out_item pending_q [$];

    // channel state as predicted
    logic        negate_extra;
    logic [1:0]  duty_sel;
    logic        halt;
    logic        const_vol;
    logic [3:0]  vol;
    logic        sweep_en;
    logic [2:0]  sweep_div;
    logic        sweep_neg;
    logic [2:0]  sweep_amt;
    logic [10:0] period;
    logic [4:0]  len_idx;
    logic        env_reload;
    logic [3:0]  env_level;
    logic        sweep_rearm;
    logic [2:0]  sweep_cnt;
    logic [10:0] timer_cnt;
    logic [2:0]  step;
    logic [7:0]  len_cnt;

    pulse_tone_channel dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [10:0] swept_period();
        logic [10:0] delta;
        logic [11:0] acc;
        delta = period >> sweep_amt;
        if (sweep_neg) begin
            acc = {1'b0, delta} + {11'd0, negate_extra};
            return (acc > {1'b0, period}) ? 11'd0 : period - acc[10:0];
        end
        acc = {1'b0, period} + {1'b0, delta};
        return (acc > {1'b0, PERIOD_CEIL}) ? PERIOD_CEIL : acc[10:0];
    endfunction

    function automatic logic [3:0] level_now();
        if (!halt && len_cnt == 8'd0)
            return 4'd0;
        if (!WAVE_BITS[duty_sel][step])
            return 4'd0;
        return const_vol ? vol : env_level;
    endfunction

    task automatic channel_step(input ptc_pkg::t_in_item it, output ptc_pkg::t_out_item res);
        logic [7:0] rd;
        rd = 8'h00;
        case (it.func)
            ptc_pkg::FUNC_WRITE: begin
                case (it.reg_addr)
                    ptc_pkg::REG_DUTY_VOL: begin
                        {duty_sel, halt, const_vol, vol} = it.write_data;
                    end
                    ptc_pkg::REG_SWEEP: begin
                        {sweep_en, sweep_div, sweep_neg, sweep_amt} = it.write_data;
                        sweep_rearm = 1'b1;
                    end
                    ptc_pkg::REG_PERIOD_LO: begin
                        period[7:0] = it.write_data;
                    end
                    default: begin
                        len_idx = it.write_data[7:3];
                        period[10:8] = it.write_data[2:0];
                        len_cnt = LEN_RELOAD[len_idx];
                        env_reload = 1'b1;
                        step = 3'd0;
                    end
                endcase
            end
            ptc_pkg::FUNC_READ: begin
                case (it.reg_addr)
                    ptc_pkg::REG_DUTY_VOL:
                        rd = {duty_sel, halt, const_vol, const_vol ? vol : env_level};
                    ptc_pkg::REG_SWEEP:
                        rd = {sweep_en, sweep_div, sweep_neg, sweep_amt};
                    ptc_pkg::REG_PERIOD_LO:
                        rd = period[7:0];
                    default:
                        rd = {len_idx, period[10:8]};
                endcase
            end
            ptc_pkg::FUNC_TIMER: begin
                if (timer_cnt != 11'd0) begin
                    timer_cnt = timer_cnt - 11'd1;
                end else begin
                    step = step + 3'd1;
                    timer_cnt = period;
                end
            end
            ptc_pkg::FUNC_ENVELOPE: begin
                if (env_reload) begin
                    env_level = ENV_FULL;
                    env_reload = 1'b0;
                end else if (env_level != 4'd0) begin
                    env_level = env_level - 4'd1;
                end else if (halt) begin
                    env_level = ENV_FULL;
                end
            end
            ptc_pkg::FUNC_LENGTH: begin
                if (!halt && len_cnt != 8'd0)
                    len_cnt = len_cnt - 8'd1;
            end
            ptc_pkg::FUNC_SWEEP: begin
                if (sweep_rearm) begin
                    if (sweep_en && sweep_cnt == 3'd0)
                        period = swept_period();
                    sweep_cnt = sweep_div;
                    sweep_rearm = 1'b0;
                end else if (sweep_cnt != 3'd0) begin
                    sweep_cnt = sweep_cnt - 3'd1;
                end else if (sweep_en) begin
                    period = swept_period();
                    sweep_cnt = sweep_div;
                end
            end
            default: ;
        endcase
        res.read_data = rd;
        res.sample = level_now();
    endtask

    // prediction and checking on the same edge, prediction first
    always @(posedge i_clk) begin
        ptc_pkg::t_out_item want;
        if (!i_rst_n) begin
            negate_extra = 1'b0;
            {duty_sel, halt, const_vol, vol} = '0;
            {sweep_en, sweep_div, sweep_neg, sweep_amt} = '0;
            period = '0;
            len_idx = '0;
            env_reload = 1'b0;
            env_level = '0;
            sweep_rearm = 1'b0;
            sweep_cnt = '0;
            timer_cnt = '0;
            step = '0;
            len_cnt = '0;
            pending_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                negate_extra = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                channel_step(i_in_item, want);
                if (row_fixed)
                    want = row_value;
                pending_q.push_back(want);
                func_seen[i_in_item.func]++;
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_LIMIT)
                        $display("unexpected result rd=%02h sample=%0d",
                                 o_out_item.read_data, o_out_item.sample);
                end else begin
                    want = pending_q.pop_front();
                    checked_count++;
                    if (o_out_item.read_data !== want.read_data ||
                        o_out_item.sample !== want.sample) begin
                        mismatch_count++;
                        if (mismatch_count <= SHOWN_LIMIT)
                            $display({"mismatch on result %0d: rd=%02h sample=%0d, ",
                                      "want rd=%02h sample=%0d"},
                                     checked_count, o_out_item.read_data,
                                     o_out_item.sample, want.read_data, want.sample);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= 12);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic feed_item(input t_row r);
        if (!steady && $urandom_range(0, 99) < 12) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= r.item;
        row_fixed  <= r.fixed;
        row_value  <= r.value;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_negate(input logic v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly ticks, with short periods so the duty steps actually turn over
    function automatic t_row pick_channel_item();
        t_row r;
        int   roll;
        r = '0;
        r.item.reg_addr = 2'($urandom_range(0, 3));
        r.item.write_data = 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            r.item.func = ptc_pkg::FUNC_WRITE;
            r.item.reg_addr = ptc_pkg::REG_DUTY_VOL;
        end else if (roll < 16) begin
            r.item.func = ptc_pkg::FUNC_WRITE;
            r.item.reg_addr = ptc_pkg::REG_SWEEP;
        end else if (roll < 22) begin
            r.item.func = ptc_pkg::FUNC_WRITE;
            r.item.reg_addr = ptc_pkg::REG_PERIOD_LO;
            if ($urandom_range(0, 9) < 7)
                r.item.write_data = 8'($urandom_range(0, 7));
        end else if (roll < 28) begin
            r.item.func = ptc_pkg::FUNC_WRITE;
            r.item.reg_addr = ptc_pkg::REG_LENGTH_HI;
            if ($urandom_range(0, 9) < 7)
                r.item.write_data[2:0] = 3'd0;
        end else if (roll < 38) begin
            r.item.func = ptc_pkg::FUNC_READ;
        end else if (roll < 60) begin
            r.item.func = ptc_pkg::FUNC_TIMER;
        end else if (roll < 72) begin
            r.item.func = ptc_pkg::FUNC_ENVELOPE;
        end else if (roll < 82) begin
            r.item.func = ptc_pkg::FUNC_LENGTH;
        end else if (roll < 95) begin
            r.item.func = ptc_pkg::FUNC_SWEEP;
        end else begin
            r.item.func = $urandom_range(0, 1) ? FUNC_SPARE_A : FUNC_SPARE_B;
        end
        return r;
    endfunction

    task automatic run_phase(input logic negate, input int count, input int calm);
        drain_results();
        set_negate(negate);
        for (int n = 0; n < count; n++) begin
            steady = (n < calm);
            feed_item(pick_channel_item());
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_negate(1'b0);
        for (int n = 0; n < SCRIPT_LEN; n++)
            feed_item(SCRIPT[n]);

        run_phase(1'b1, 350, 150);
        run_phase(1'b0, 300, 0);
        run_phase(1'b1, 350, 0);

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("%0d results checked, %0d mismatches, extra-one negate run both off and on",
                 checked_count, mismatch_count);
        $display("writes %0d reads %0d timer %0d envelope %0d length %0d sweep %0d unused %0d",
                 func_seen[ptc_pkg::FUNC_WRITE], func_seen[ptc_pkg::FUNC_READ],
                 func_seen[ptc_pkg::FUNC_TIMER], func_seen[ptc_pkg::FUNC_ENVELOPE],
                 func_seen[ptc_pkg::FUNC_LENGTH], func_seen[ptc_pkg::FUNC_SWEEP],
                 func_seen[FUNC_SPARE_A] + func_seen[FUNC_SPARE_B]);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
